>>> src/cua_pkg.sv
// Shared constants, handshake structs and helpers for the CPU utilization averager.
package cua_pkg;

    // Default ring length for the moving averages.
    localparam int HISTORY_DEPTH_DEF = 5;

    // Field and datapath widths.
    localparam int TICK_W  = 31;
    localparam int CTR_W   = 63;
    localparam int DELTA_W = 64;
    localparam int WIDE_W  = 66;
    localparam int PROD_W  = 71;
    localparam int DIV_W   = 64;
    localparam int QUO_W   = 15;
    localparam int STEP_W  = 4;
    localparam int SYS_W   = 7;
    localparam int PROC_W  = 15;

    localparam logic [TICK_W-1:0] MIN_INTERVAL_RST = 31'd200;
    localparam logic [SYS_W-1:0]  SYS_MAX          = 7'd100;
    localparam logic [PROC_W-1:0] PROC_MAX         = 15'h7fff;
    localparam logic [STEP_W-1:0] SYS_STEPS        = 4'd7;
    localparam logic [STEP_W-1:0] PROC_STEPS       = 4'd15;

    // Register index of the minimum interval register.
    localparam logic REG_MIN_INTERVAL = 1'b0;

    // Command to the shared divider: the remainder starts at rem_init and the
    // quotient bits come from shifting in low_bits, most significant first.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [QUO_W-1:0]  low_bits;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  divisor;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Multiply by 100 as a sum of three shifts.
    function automatic logic [PROD_W-1:0] times100(input logic [DIV_W-1:0] x);
        logic [PROD_W-1:0] xw;
        xw = {{(PROD_W-DIV_W){1'b0}}, x};
        return (xw << 6) + (xw << 5) + (xw << 2);
    endfunction

endpackage

>>> src/cua_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module cua_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cua_pkg::div_cmd_t             cmd_i,
    output cua_pkg::div_sts_t             sts_o,
    output logic [cua_pkg::QUO_W-1:0]     quo_o
);
    import cua_pkg::*;

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  low_reg, low_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    shifted;
    logic [DIV_W+1:0]  trial;
    logic              fits;

    // Shift in the next dividend bit and try a subtraction.
    assign shifted = {rem_reg, low_reg[QUO_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~trial[DIV_W+1];

    // Load on start, then step until the count runs out.
    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd_i.start) begin
            rem_next = cmd_i.rem_init;
            low_next = cmd_i.low_bits;
            den_next = cmd_i.divisor;
            quo_next = '0;
            cnt_next = cmd_i.steps;
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            low_next  = {low_reg[QUO_W-2:0], 1'b0};
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign sts_o.busy = (cnt_reg != '0);
    assign sts_o.done = done_reg;
    assign quo_o      = quo_reg;

`ifndef SYNTHESIS
    // A new division is never started on top of one in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.start |-> (cnt_reg == '0))
        else $error("divider started while busy");

    // While stepping, the partial remainder stays below a nonzero divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> ((rem_reg < den_reg) && (den_reg != '0)))
        else $error("divider remainder out of range");

    // Done follows the last step only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(cnt_reg) == STEP_W'(1)))
        else $error("divider done without a final step");
`endif

endmodule

>>> src/cua_hist.sv
// History ring storage for the system and process percentages.
module cua_hist #(
    parameter int DEPTH = cua_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [cua_pkg::SYS_W-1:0]         wr_sys,
    input  logic [cua_pkg::PROC_W-1:0]        wr_proc,
    input  logic                              rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [cua_pkg::SYS_W-1:0]         rd_sys,
    output logic [cua_pkg::PROC_W-1:0]        rd_proc
);
    import cua_pkg::*;

    logic [SYS_W-1:0]  sys_mem  [DEPTH];
    logic [PROC_W-1:0] proc_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sys_mem[wr_addr]  <= wr_sys;
            proc_mem[wr_addr] <= wr_proc;
        end
        if (rd_en) begin
            rd_sys  <= sys_mem[rd_addr];
            rd_proc <= proc_mem[rd_addr];
        end
    end

endmodule

>>> src/cpu_utilization_averager.sv
// CPU utilization averager: one sample of cumulative time counters per beat in,
// one averaged utilization result per beat out. A sample that arrives no more
// than min_interval_ms milliseconds (31-bit wrap) after the last taken sample
// repeats the last result with updated low. The first taken sample only stores
// the baseline and reports 0, 0. Every later taken sample forms the counter
// deltas, computes the system and process busy percentages and averages them
// over the last HISTORY_DEPTH measurements. One restoring divider, one quotient
// bit per cycle, is shared by all four divisions, and the history sum reads the
// ring one entry per cycle. The block takes one sample at a time: s_ready is
// high only when no sample is in flight.
module cpu_utilization_averager #(
    parameter int HISTORY_DEPTH = cua_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_now_tick_ms,
    input  logic [cua_pkg::CTR_W-1:0]        s_wall_time,
    input  logic [cua_pkg::CTR_W-1:0]        s_idle_total,
    input  logic [cua_pkg::CTR_W-1:0]        s_kernel_total,
    input  logic [cua_pkg::CTR_W-1:0]        s_user_total,
    input  logic [cua_pkg::CTR_W-1:0]        s_proc_kernel_total,
    input  logic [cua_pkg::CTR_W-1:0]        s_proc_user_total,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cua_pkg::PROC_W-1:0]       m_process_usage_pct,
    output logic [cua_pkg::SYS_W-1:0]        m_system_usage_pct,
    output logic                             m_updated
);
    import cua_pkg::*;

    localparam int ADDR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_S_W = SYS_W + FILL_W;
    localparam int SUM_P_W = PROC_W + FILL_W;

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_CHECK   = 18'h00002,
        ST_DIFF    = 18'h00004,
        ST_SUM     = 18'h00008,
        ST_ABS     = 18'h00010,
        ST_SMUL    = 18'h00020,
        ST_SGO     = 18'h00040,
        ST_SWAIT   = 18'h00080,
        ST_PMUL    = 18'h00100,
        ST_PGO     = 18'h00200,
        ST_PWAIT   = 18'h00400,
        ST_STORE   = 18'h00800,
        ST_ACC     = 18'h01000,
        ST_AGO_S   = 18'h02000,
        ST_AWAIT_S = 18'h04000,
        ST_AGO_P   = 18'h08000,
        ST_AWAIT_P = 18'h10000,
        ST_OUT     = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [TICK_W-1:0]  min_int_reg;
    logic [TICK_W-1:0]  tick_reg, now_reg;
    logic               baseline_reg;
    logic [CTR_W-1:0]   in_wall_reg, in_idle_reg, in_kern_reg, in_user_reg;
    logic [CTR_W-1:0]   in_pk_reg, in_pu_reg;
    logic [CTR_W-1:0]   prev_wall_reg, prev_idle_reg, prev_kern_reg, prev_user_reg;
    logic [CTR_W-1:0]   prev_pk_reg, prev_pu_reg;
    logic [DELTA_W-1:0] d_wall_reg, d_idle_reg, d_kern_reg, d_user_reg;
    logic [DELTA_W-1:0] d_pk_reg, d_pu_reg;
    logic [WIDE_W-1:0]  sys_reg, num_reg, busy_reg;
    logic [DIV_W-1:0]   as_reg, ab_reg, aw_reg;
    logic [DIV_W:0]     an_reg;
    logic               s_skip_reg, p_skip_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SYS_W-1:0]   s_pct_reg;
    logic [PROC_W-1:0]  p_pct_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [FILL_W-1:0]  fill_reg, acc_cnt_reg;
    logic [SUM_S_W-1:0] sum_s_reg;
    logic [SUM_P_W-1:0] sum_p_reg;
    logic [SYS_W-1:0]   last_s_reg;
    logic [PROC_W-1:0]  last_p_reg;
    logic [PROC_W-1:0]  m_proc_reg;
    logic [SYS_W-1:0]   m_sys_reg;
    logic               m_upd_reg;

    logic [TICK_W-1:0]  elapsed;
    logic [WIDE_W-1:0]  sx_du, sx_dk, sx_di, sx_dpu, sx_dpk, sx_dw;
    logic [WIDE_W-1:0]  abs_sys, abs_num, abs_busy, abs_wall;
    logic               proc_sat;
    logic               cfg_wr;
    div_cmd_t           div_cmd;
    div_sts_t           div_sts;
    logic [QUO_W-1:0]   div_quo;
    logic               hist_wr, hist_rd;
    logic [SYS_W-1:0]   hist_sys;
    logic [PROC_W-1:0]  hist_proc;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_MIN_INTERVAL) ? {1'b0, min_int_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_int_reg <= MIN_INTERVAL_RST;
        end else if (cfg_wr && (paddr[2] == REG_MIN_INTERVAL)) begin
            min_int_reg <= pwdata[TICK_W-1:0];
        end
    end

    // Datapath helpers.
    assign elapsed  = now_reg - tick_reg;
    assign sx_du    = {{(WIDE_W-DELTA_W){d_user_reg[DELTA_W-1]}}, d_user_reg};
    assign sx_dk    = {{(WIDE_W-DELTA_W){d_kern_reg[DELTA_W-1]}}, d_kern_reg};
    assign sx_di    = {{(WIDE_W-DELTA_W){d_idle_reg[DELTA_W-1]}}, d_idle_reg};
    assign sx_dpu   = {{(WIDE_W-DELTA_W){d_pu_reg[DELTA_W-1]}}, d_pu_reg};
    assign sx_dpk   = {{(WIDE_W-DELTA_W){d_pk_reg[DELTA_W-1]}}, d_pk_reg};
    assign sx_dw    = {{(WIDE_W-DELTA_W){d_wall_reg[DELTA_W-1]}}, d_wall_reg};
    assign abs_sys  = sys_reg[WIDE_W-1] ? (~sys_reg + WIDE_W'(1)) : sys_reg;
    assign abs_num  = num_reg[WIDE_W-1] ? (~num_reg + WIDE_W'(1)) : num_reg;
    assign abs_busy = busy_reg[WIDE_W-1] ? (~busy_reg + WIDE_W'(1)) : busy_reg;
    assign abs_wall = sx_dw[WIDE_W-1] ? (~sx_dw + WIDE_W'(1)) : sx_dw;
    assign proc_sat = {{(DIV_W-(PROD_W-QUO_W)){1'b0}}, prod_reg[PROD_W-1:QUO_W]} >= aw_reg;

    // Divider command per state.
    always_comb begin
        div_cmd = '0;
        case (state_reg)
            ST_SGO: begin
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = prod_reg[PROD_W-1:SYS_W];
                div_cmd.low_bits = {prod_reg[SYS_W-1:0], {(QUO_W-SYS_W){1'b0}}};
                div_cmd.steps    = SYS_STEPS;
                div_cmd.divisor  = as_reg;
            end
            ST_PGO: begin
                div_cmd.start    = ~proc_sat;
                div_cmd.rem_init = {{(DIV_W-(PROD_W-QUO_W)){1'b0}},
                                    prod_reg[PROD_W-1:QUO_W]};
                div_cmd.low_bits = prod_reg[QUO_W-1:0];
                div_cmd.steps    = PROC_STEPS;
                div_cmd.divisor  = aw_reg;
            end
            ST_AGO_S: begin
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = {{(DIV_W-FILL_W){1'b0}}, sum_s_reg[SUM_S_W-1:SYS_W]};
                div_cmd.low_bits = {sum_s_reg[SYS_W-1:0], {(QUO_W-SYS_W){1'b0}}};
                div_cmd.steps    = SYS_STEPS;
                div_cmd.divisor  = {{(DIV_W-FILL_W){1'b0}}, fill_reg};
            end
            ST_AGO_P: begin
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = {{(DIV_W-FILL_W){1'b0}}, sum_p_reg[SUM_P_W-1:PROC_W]};
                div_cmd.low_bits = sum_p_reg[PROC_W-1:0];
                div_cmd.steps    = PROC_STEPS;
                div_cmd.divisor  = {{(DIV_W-FILL_W){1'b0}}, fill_reg};
            end
            default: begin
                div_cmd = '0;
            end
        endcase
    end

    cua_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (div_cmd),
        .sts_o   (div_sts),
        .quo_o   (div_quo)
    );

    // History ring access.
    assign hist_wr = (state_reg == ST_STORE);
    assign hist_rd = (state_reg == ST_ACC) && (acc_cnt_reg < fill_reg);

    cua_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (hist_wr),
        .wr_addr (pos_reg),
        .wr_sys  (s_pct_reg),
        .wr_proc (p_pct_reg),
        .rd_en   (hist_rd),
        .rd_addr (acc_cnt_reg[ADDR_W-1:0]),
        .rd_sys  (hist_sys),
        .rd_proc (hist_proc)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (elapsed <= min_int_reg || !baseline_reg) state_next = ST_OUT;
                else state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_ABS;
            ST_ABS:   state_next = ST_SMUL;
            ST_SMUL: begin
                if (s_skip_reg || an_reg >= {1'b0, as_reg}) state_next = ST_PMUL;
                else state_next = ST_SGO;
            end
            ST_SGO:   state_next = ST_SWAIT;
            ST_SWAIT: begin
                if (div_sts.done) state_next = ST_PMUL;
            end
            ST_PMUL: begin
                if (p_skip_reg) state_next = ST_STORE;
                else state_next = ST_PGO;
            end
            ST_PGO: begin
                if (proc_sat) state_next = ST_STORE;
                else state_next = ST_PWAIT;
            end
            ST_PWAIT: begin
                if (div_sts.done) state_next = ST_STORE;
            end
            ST_STORE: state_next = ST_ACC;
            ST_ACC: begin
                if (acc_cnt_reg == fill_reg) state_next = ST_AGO_S;
            end
            ST_AGO_S:   state_next = ST_AWAIT_S;
            ST_AWAIT_S: begin
                if (div_sts.done) state_next = ST_AGO_P;
            end
            ST_AGO_P:   state_next = ST_AWAIT_P;
            ST_AWAIT_P: begin
                if (div_sts.done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            baseline_reg <= 1'b0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            acc_cnt_reg  <= '0;
            last_s_reg   <= '0;
            last_p_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_CHECK: begin
                    if (elapsed > min_int_reg && !baseline_reg) begin
                        baseline_reg <= 1'b1;
                        tick_reg     <= now_reg;
                        last_s_reg   <= '0;
                        last_p_reg   <= '0;
                    end
                end
                ST_DIFF: begin
                    tick_reg <= now_reg;
                end
                ST_STORE: begin
                    pos_reg     <= (pos_reg == ADDR_W'(HISTORY_DEPTH - 1)) ?
                                   '0 : pos_reg + ADDR_W'(1);
                    if (fill_reg < FILL_W'(HISTORY_DEPTH)) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                    acc_cnt_reg <= '0;
                end
                ST_ACC: begin
                    if (acc_cnt_reg != fill_reg) acc_cnt_reg <= acc_cnt_reg + FILL_W'(1);
                end
                ST_AWAIT_S: begin
                    if (div_sts.done) last_s_reg <= div_quo[SYS_W-1:0];
                end
                ST_AWAIT_P: begin
                    if (div_sts.done) last_p_reg <= div_quo;
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_reg     <= s_now_tick_ms[TICK_W-1:0];
                    in_wall_reg <= s_wall_time;
                    in_idle_reg <= s_idle_total;
                    in_kern_reg <= s_kernel_total;
                    in_user_reg <= s_user_total;
                    in_pk_reg   <= s_proc_kernel_total;
                    in_pu_reg   <= s_proc_user_total;
                end
            end
            ST_CHECK: begin
                if (elapsed <= min_int_reg) begin
                    m_proc_reg <= last_p_reg;
                    m_sys_reg  <= last_s_reg;
                    m_upd_reg  <= 1'b0;
                end else if (!baseline_reg) begin
                    prev_wall_reg <= in_wall_reg;
                    prev_idle_reg <= in_idle_reg;
                    prev_kern_reg <= in_kern_reg;
                    prev_user_reg <= in_user_reg;
                    prev_pk_reg   <= in_pk_reg;
                    prev_pu_reg   <= in_pu_reg;
                    m_proc_reg    <= '0;
                    m_sys_reg     <= '0;
                    m_upd_reg     <= 1'b1;
                end
            end
            ST_DIFF: begin
                d_wall_reg    <= {1'b0, in_wall_reg} - {1'b0, prev_wall_reg};
                d_idle_reg    <= {1'b0, in_idle_reg} - {1'b0, prev_idle_reg};
                d_kern_reg    <= {1'b0, in_kern_reg} - {1'b0, prev_kern_reg};
                d_user_reg    <= {1'b0, in_user_reg} - {1'b0, prev_user_reg};
                d_pk_reg      <= {1'b0, in_pk_reg} - {1'b0, prev_pk_reg};
                d_pu_reg      <= {1'b0, in_pu_reg} - {1'b0, prev_pu_reg};
                prev_wall_reg <= in_wall_reg;
                prev_idle_reg <= in_idle_reg;
                prev_kern_reg <= in_kern_reg;
                prev_user_reg <= in_user_reg;
                prev_pk_reg   <= in_pk_reg;
                prev_pu_reg   <= in_pu_reg;
            end
            ST_SUM: begin
                sys_reg  <= sx_du + sx_dk;
                num_reg  <= sx_du + sx_dk - sx_di;
                busy_reg <= sx_dpu + sx_dpk;
            end
            ST_ABS: begin
                as_reg     <= abs_sys[DIV_W-1:0];
                an_reg     <= abs_num[DIV_W:0];
                ab_reg     <= abs_busy[DIV_W-1:0];
                aw_reg     <= abs_wall[DIV_W-1:0];
                s_skip_reg <= (sys_reg == '0) || (num_reg == '0) ||
                              (sys_reg[WIDE_W-1] != num_reg[WIDE_W-1]);
                p_skip_reg <= (busy_reg == '0) || (sx_dw == '0) ||
                              (busy_reg[WIDE_W-1] != sx_dw[WIDE_W-1]);
            end
            ST_SMUL: begin
                if (s_skip_reg) s_pct_reg <= '0;
                else if (an_reg >= {1'b0, as_reg}) s_pct_reg <= SYS_MAX;
                else prod_reg <= times100(an_reg[DIV_W-1:0]);
            end
            ST_SWAIT: begin
                if (div_sts.done) s_pct_reg <= div_quo[SYS_W-1:0];
            end
            ST_PMUL: begin
                if (p_skip_reg) p_pct_reg <= '0;
                else prod_reg <= times100(ab_reg);
            end
            ST_PGO: begin
                if (proc_sat) p_pct_reg <= PROC_MAX;
            end
            ST_PWAIT: begin
                if (div_sts.done) p_pct_reg <= div_quo;
            end
            ST_STORE: begin
                sum_s_reg <= '0;
                sum_p_reg <= '0;
            end
            ST_ACC: begin
                if (acc_cnt_reg != '0) begin
                    sum_s_reg <= sum_s_reg + SUM_S_W'(hist_sys);
                    sum_p_reg <= sum_p_reg + SUM_P_W'(hist_proc);
                end
            end
            ST_AWAIT_P: begin
                if (div_sts.done) begin
                    m_proc_reg <= div_quo;
                    m_sys_reg  <= last_s_reg;
                    m_upd_reg  <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Handshake outputs.
    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = (state_reg == ST_OUT);
    assign m_process_usage_pct = m_proc_reg;
    assign m_system_usage_pct  = m_sys_reg;
    assign m_updated           = m_upd_reg;

`ifndef SYNTHESIS
    // Only one sample is in flight: no new beat while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // The fill count never passes the ring length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill count overflow");

    // A repeated result shows the last stored averages.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_updated) |->
            (m_process_usage_pct == last_p_reg) && (m_system_usage_pct == last_s_reg))
        else $error("repeated result differs from last averages");

    // The averaged system percentage stays within range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_system_usage_pct <= SYS_MAX))
        else $error("system percentage above limit");
`endif

endmodule
